@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the hasher RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check that antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ hw/rtl/sha_pkg.sv @@
// Types and constants of the SHA-256/224 byte stream hasher
package sha_pkg;
   typedef logic [31:0] word_type;
   typedef word_type [7:0] hash_type;

   localparam hash_type INIT_256 = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};
   localparam hash_type INIT_224 = {
      32'hbefa4fa4, 32'h64f98fa7, 32'h68581511, 32'hffc00b31,
      32'hf70e5939, 32'h3070dd17, 32'h367cd507, 32'hc1059ed8};
   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_RUN   = 6'b000010,
      ST_ADD   = 6'b000100,
      ST_PAD   = 6'b001000,
      ST_LEN   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   // compression control from sequencer to round unit
   typedef struct packed {
      logic start;
      logic run;
      logic [5:0] round;
   } round_ctl_type;

   function automatic word_type round_k(input logic [5:0] r);
      word_type k;
      case (r)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction
endpackage

@@ hw/rtl/sha_ifc.sv @@
// Valid/ready channel interfaces of the hasher
interface sha_req_ifc;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;
   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_rsp_ifc;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;
   modport source (output valid, digest_word, word_number, last_word, input ready);
   modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

interface sha_csr_ifc;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/sha_round.sv @@
// Shared SHA-256 round unit with rolling 16-word message schedule
module sha_round (
   input  logic                   clock,
   input  sha_pkg::round_ctl_type ctl,
   input  sha_pkg::hash_type      init_value,
   input  sha_pkg::word_type      blk [16],
   output sha_pkg::hash_type      work_value
);
   import sha_pkg::*;

   hash_type v_ff, v_in;
   word_type w_ff [16];
   word_type w_in [16];
   word_type wr, s0, s1, t1, t2, x, y;

   always_comb begin
      x  = w_ff[1];
      y  = w_ff[14];
      s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
      s1 = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
      wr = (ctl.round < 6'd16) ? w_ff[0] : (w_ff[0] + s0 + s1 + w_ff[9]);
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(ctl.round) + wr;
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      v_in = v_ff;
      w_in = w_ff;
      if (ctl.start) begin
         v_in = init_value;
         w_in = blk;
      end else if (ctl.run) begin
         for (int k = 7; k > 0; k--) v_in[k] = v_ff[k-1];
         v_in[4] = v_ff[3] + t1;
         v_in[0] = t1 + t2;
         // rotate window so slot 0 is always the current word
         for (int k = 0; k < 15; k++) w_in[k] = w_ff[k+1];
         w_in[15] = wr;
      end
   end

   // hold working variables and schedule between rounds
   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

   assign work_value = v_ff;
endmodule

@@ hw/rtl/sha256_byte_stream_hasher_top.sv @@
// Top level of the SHA-256/224 byte stream hasher
// Usage:
//  req channel: one item per step: data_byte with byte_present, and
//    end_of_message. Config channel csr: one bit, 0 = SHA-256, 1 = SHA-224;
//    write only while idle; a write drops any message in progress.
//  rsp channel: after an item with end_of_message, eight (or seven) digest
//    words, word 0 first, last_word on the final one.
//  Sequencing: a byte that does not fill a block is stored and the hasher
//    stays idle. A byte that fills a block starts a compression: a load of
//    the shared round unit, its 64 rounds, then a step that adds the
//    chaining value. End of message runs one or two more compressions, then
//    the words go out one per cycle the receiver accepts.
//  req_ready is low while padding, a compression or the digest output is
//    underway, and while a config write is offered.
//  Reset loads the SHA-256 initial value, clears the byte count and mode.
//  A stalled receiver holds the current word; nothing is lost.
`include "assert_macros.svh"
module sha256_byte_stream_hasher_top (
   input logic clock,
   input logic reset,
   sha_req_ifc.sink   req,
   sha_rsp_ifc.source rsp,
   sha_csr_ifc.sink   csr
);
   import sha_pkg::*;

   state_type     state_ff, state_in;
   logic          mode_ff, mode_in;
   hash_type      hash_ff, hash_in;
   word_type      blk_ff [16];
   word_type      blk_in [16];
   logic [60:0]   count_ff, count_in;
   logic [6:0]    rnd_ff, rnd_in;
   logic          fin_ff, fin_in;    // finishing the message
   logic          pad_ff, pad_in;    // padding already written
   logic          two_ff, two_in;    // extra block still due
   logic [2:0]    wnum_ff, wnum_in;
   hash_type      work;
   round_ctl_type ctl;
   logic [5:0]    pos;
   logic [63:0]   bits;
   logic          take;
   logic [2:0]    last_idx;

   sha_round u_round (.clock(clock), .ctl(ctl), .init_value(hash_ff), .blk(blk_ff),
                      .work_value(work));

   assign req.ready = (state_ff == ST_IDLE) && !csr.valid;
   assign csr.ready = (state_ff == ST_IDLE);
   assign take      = req.valid && req.ready;
   assign pos       = count_ff[5:0];
   assign bits      = {count_ff, 3'b000};
   assign last_idx  = mode_ff ? 3'd6 : 3'd7;

   assign rsp.valid       = (state_ff == ST_OUT);
   assign rsp.digest_word = hash_ff[wnum_ff];
   assign rsp.word_number = wnum_ff;
   assign rsp.last_word   = (wnum_ff == last_idx);

   // round control: round counter value 0 loads, rounds follow
   always_comb begin
      ctl.start = (state_ff == ST_RUN) && (rnd_ff == 7'd0);
      ctl.run   = (state_ff == ST_RUN) && (rnd_ff != 7'd0);
      ctl.round = rnd_ff[5:0] - 6'd1;
   end

   // sequencer
   always_comb begin
      logic [5:0] p;
      logic [3:0] idx;
      state_in = state_ff;
      mode_in  = mode_ff;
      hash_in  = hash_ff;
      blk_in   = blk_ff;
      count_in = count_ff;
      rnd_in   = rnd_ff;
      fin_in   = fin_ff;
      pad_in   = pad_ff;
      two_in   = two_ff;
      wnum_in  = wnum_ff;
      p = pos;
      idx = pos[5:2];
      case (state_ff)
         ST_IDLE: begin
            if (csr.valid) begin
               mode_in  = csr.data;
               hash_in  = csr.data ? INIT_224 : INIT_256;
               count_in = '0;
            end else if (take) begin
               if (req.byte_present) begin
                  if (p[1:0] == 2'd0) blk_in[idx] = '0;
                  blk_in[idx][(3 - p[1:0]) * 8 +: 8] = req.data_byte;
                  count_in = count_ff + 61'd1;
                  p = p + 6'd1;
               end
               fin_in = req.end_of_message;
               rnd_in = '0;
               if (req.byte_present && p == 6'd0) state_in = ST_RUN;
               else if (req.end_of_message) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            // marker and zero fill after the last byte
            if (p[1:0] == 2'd0) blk_in[idx] = '0;
            blk_in[idx][(3 - p[1:0]) * 8 +: 8] = PAD_MARK;
            for (int k = 0; k < 16; k++)
               if (k > idx) blk_in[k] = '0;
            two_in = (pos >= 6'd56);
            pad_in = 1'b1;
            state_in = ST_LEN;
         end
         ST_LEN: begin
            if (!two_ff) begin
               blk_in[14] = bits[63:32];
               blk_in[15] = bits[31:0];
            end
            rnd_in = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd64) state_in = ST_ADD;
         end
         ST_ADD: begin
            for (int k = 0; k < 8; k++) hash_in[k] = hash_ff[k] + work[k];
            wnum_in = '0;
            if (!fin_ff) state_in = ST_IDLE;
            else if (!pad_ff) state_in = ST_PAD;
            else if (two_ff) begin
               for (int k = 0; k < 14; k++) blk_in[k] = '0;
               two_in = 1'b0;
               state_in = ST_LEN;
            end else state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp.ready) begin
               wnum_in = wnum_ff + 3'd1;
               if (wnum_ff == last_idx) begin
                  hash_in  = mode_ff ? INIT_224 : INIT_256;
                  count_in = '0;
                  fin_in   = 1'b0;
                  pad_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= 1'b0;
         hash_ff  <= INIT_256;
         count_ff <= '0;
         rnd_ff   <= '0;
         fin_ff   <= 1'b0;
         pad_ff   <= 1'b0;
         two_ff   <= 1'b0;
         wnum_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         hash_ff  <= hash_in;
         count_ff <= count_in;
         rnd_ff   <= rnd_in;
         fin_ff   <= fin_in;
         pad_ff   <= pad_in;
         two_ff   <= two_in;
         wnum_ff  <= wnum_in;
      end
   end

   // hold block buffer
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   `ASSERT_IMPLY(a_out_only_fin, clock, reset, rsp.valid, fin_ff)
   `ASSERT_IMPLY(a_round_range, clock, reset, state_ff == ST_RUN, rnd_ff <= 7'd64)
   `ASSERT_NEXT(a_last_to_idle, clock, reset, rsp.valid && rsp.ready && rsp.last_word,
                state_ff == ST_IDLE)
endmodule
